### hw/rtl/ket_pkg.sv
// ket_pkg: shared widths, defaults and register indexes for the keyed
// execution-time tracker
// no dependencies
package ket_pkg;

  // default geometry
  localparam int OP_KINDS_DEF   = 8;
  localparam int UNIT_KINDS_DEF = 4;
  localparam int MAX_WINDOW_DEF = 32;

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int UNIT_W  = 2;
  localparam int TIME_W  = 48;
  localparam int SUM_W   = 64;
  localparam int CNT_W   = 32;
  localparam int LIMIT_W = 6;

  // register defaults
  localparam logic               MODE_RESET  = 1'b1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd25;

  // register indexes
  localparam logic REG_STAT_MODE    = 1'b0;
  localparam logic REG_WINDOW_LIMIT = 1'b1;

  // stat modes
  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

endpackage

### hw/rtl/keyed_exec_time_tracker.sv
// keyed_exec_time_tracker: per-key running mean or sliding-window median of
// timing samples, built round one shared divider step and one comparator
// depends on ket_pkg

// After reset the block clears its per-key statistics store and holds
// in_stall high meanwhile. One sample is worked at a time; in_stall stays
// high until its result beat is loaded into the output register. In mean mode
// a sample passes through an update state, 64 steps of a one-bit-per-cycle
// restoring divider for the 64 by 32 bit division, and an output state that
// loads the result once the output register is free. In median mode the
// window is read back from the single-port history memory one sample a
// cycle; each candidate is read and then ranked against the whole window,
// and candidates are tried in arrival order until the one at sorted index
// fill/2 turns up.
module keyed_exec_time_tracker
  import ket_pkg::*;
#(
  parameter int OP_KINDS   = OP_KINDS_DEF,
  parameter int UNIT_KINDS = UNIT_KINDS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_data,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op_kind,
  input  logic [UNIT_W-1:0]  unit_kind,
  input  logic [TIME_W-1:0]  sample_time,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TIME_W-1:0]  estimate,
  output logic [LIMIT_W-1:0] window_fill,
  output logic               saturated
);

  localparam int KEYS    = OP_KINDS * UNIT_KINDS;
  localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
  localparam int HDEPTH  = KEYS * MAX_WINDOW;
  localparam int HADDR_W = $clog2(HDEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CAND  = 3'd4;
  localparam logic [2:0] S_CLOAD = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] old;
  } rec_t;

  // ring slot arithmetic, both operands below or at the window size
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [FILL_W-1:0] b);
    logic [FILL_W:0] s;
    s = (FILL_W+1)'(a) + (FILL_W+1)'(b);
    if (s >= (FILL_W+1)'(MAX_WINDOW)) s = s - (FILL_W+1)'(MAX_WINDOW);
    return SLOT_W'(s);
  endfunction

  // key folding for out-of-range kinds
  function automatic logic [KEY_W-1:0] key_of(input logic [OP_W-1:0] op,
                                              input logic [UNIT_W-1:0] un);
    logic [6:0] ro;
    logic [4:0] ru;
    ro = 7'(op);
    ru = 5'(un);
    for (int k = 0; k < 8; k++) begin
      if (ro >= 7'(OP_KINDS)) ro = ro - 7'(OP_KINDS);
    end
    for (int k = 0; k < 4; k++) begin
      if (ru >= 5'(UNIT_KINDS)) ru = ru - 5'(UNIT_KINDS);
    end
    return KEY_W'(int'(ro) * UNIT_KINDS + int'(ru));
  endfunction

  // configuration registers
  logic               stat_mode;
  logic [LIMIT_W-1:0] window_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_mode    <= MODE_RESET;
      window_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAT_MODE:    stat_mode    <= cfg_data[0];
        REG_WINDOW_LIMIT: window_limit <= cfg_data;
        default:          ;
      endcase
    end
  end

  // sequencer and working registers
  logic [2:0]        state;
  logic [KEY_W-1:0]  clr_addr;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] t_r;
  logic              mode_r;
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] old_r;
  logic [FILL_W-1:0] cand_i;
  logic [FILL_W-1:0] iss_j;
  logic              pend;
  logic [FILL_W-1:0] pend_j;
  logic [TIME_W-1:0] cand;
  logic [FILL_W-1:0] rank;
  logic [SUM_W-1:0]  div_q;
  logic [CNT_W-1:0]  div_rem;
  logic [CNT_W-1:0]  div_c;
  logic [5:0]        div_n;
  logic              sat_r;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // per-key statistics store
  rec_t             kmem [KEYS];
  rec_t             krd;
  rec_t             kwr;
  logic             kwe;
  logic [KEY_W-1:0] kaddr;

  always_comb begin
    case (state)
      S_CLEAR: kaddr = clr_addr;
      S_IDLE:  kaddr = key_of(op_kind, unit_kind);
      default: kaddr = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kwe) kmem[kaddr] <= kwr;
    krd <= kmem[kaddr];
  end

  // sample history, one ring of MAX_WINDOW per key
  logic [TIME_W-1:0]  hist [HDEPTH];
  logic [TIME_W-1:0]  hrd;
  logic               hwe;
  logic [SLOT_W-1:0]  hslot;
  logic [HADDR_W-1:0] haddr;

  assign haddr = HADDR_W'(int'(key_r) * MAX_WINDOW + int'(hslot));

  always_ff @(posedge clk) begin
    if (hwe) hist[haddr] <= t_r;
    hrd <= hist[haddr];
  end

  // effective window limit
  logic [FILL_W-1:0] lim;
  always_comb begin
    if (window_limit == '0) lim = FILL_W'(1);
    else if (int'(window_limit) > MAX_WINDOW) lim = FILL_W'(MAX_WINDOW);
    else lim = FILL_W'(window_limit);
  end

  // median ring update
  logic [FILL_W-1:0] f0, f1, f2;
  logic [SLOT_W-1:0] o1, o2, wslot;
  always_comb begin
    f0 = (int'(krd.fill) > MAX_WINDOW) ? FILL_W'(MAX_WINDOW) : krd.fill;
    o1 = krd.old;
    f1 = f0;
    if (f0 > lim) begin
      o1 = slot_add(krd.old, f0 - lim);
      f1 = lim;
    end
    if (f1 < lim) begin
      wslot = slot_add(o1, f1);
      f2    = f1 + FILL_W'(1);
      o2    = o1;
    end else begin
      wslot = o1;
      f2    = f1;
      o2    = slot_add(o1, FILL_W'(1));
    end
  end

  // mean update with saturation
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  assign sum_ext = (SUM_W+1)'(krd.sum) + (SUM_W+1)'(t_r);
  assign sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign cnt_new = (krd.cnt == {CNT_W{1'b1}}) ? krd.cnt : krd.cnt + CNT_W'(1);

  // shared divider step
  logic [CNT_W:0]   div_try;
  logic             div_bit;
  assign div_try = {div_rem, div_q[SUM_W-1]};
  assign div_bit = (div_try >= {1'b0, div_c});

  // shared comparator for rank counting
  logic less;
  assign less = (hrd < cand) || ((hrd == cand) && (pend_j < cand_i));

  // store writes and history addressing
  always_comb begin
    kwe   = 1'b0;
    kwr   = krd;
    hwe   = 1'b0;
    hslot = slot_add(old_r, iss_j);
    case (state)
      S_CLEAR: begin
        kwe = 1'b1;
        kwr = '0;
      end
      S_UPD: begin
        kwe = 1'b1;
        if (mode_r == MODE_MEAN) begin
          kwr.sum = sum_new;
          kwr.cnt = cnt_new;
        end else begin
          kwr.fill = f2;
          kwr.old  = o2;
          hwe      = 1'b1;
          hslot    = wslot;
        end
      end
      S_CAND:  hslot = slot_add(old_r, cand_i);
      default: ;
    endcase
  end

  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + KEY_W'(1);
          if (int'(clr_addr) == KEYS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            key_r  <= kaddr;
            t_r    <= sample_time;
            mode_r <= stat_mode;
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          if (mode_r == MODE_MEAN) begin
            div_q   <= sum_new;
            div_c   <= cnt_new;
            div_rem <= '0;
            div_n   <= '0;
            sat_r   <= (sum_new == {SUM_W{1'b1}}) || (cnt_new == {CNT_W{1'b1}});
            state   <= S_DIV;
          end else begin
            fill_r <= f2;
            old_r  <= o2;
            cand_i <= '0;
            state  <= S_CAND;
          end
        end
        S_DIV: begin
          div_rem <= div_bit ? CNT_W'(div_try - {1'b0, div_c}) : CNT_W'(div_try);
          div_q   <= {div_q[SUM_W-2:0], div_bit};
          div_n   <= div_n + 6'd1;
          if (div_n == 6'd63) state <= S_OUT;
        end
        S_CAND: state <= S_CLOAD;
        S_CLOAD: begin
          cand  <= hrd;
          iss_j <= '0;
          pend  <= 1'b0;
          rank  <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (iss_j < fill_r) begin
            iss_j  <= iss_j + FILL_W'(1);
            pend   <= 1'b1;
            pend_j <= iss_j;
          end else begin
            pend <= 1'b0;
          end
          if (pend && less) rank <= rank + FILL_W'(1);
          if ((iss_j == fill_r) && !pend) begin
            if (rank == (fill_r >> 1)) begin
              state <= S_OUT;
            end else begin
              cand_i <= cand_i + FILL_W'(1);
              state  <= S_CAND;
            end
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (mode_r == MODE_MEAN) begin
        estimate    <= (div_q[SUM_W-1:TIME_W] != '0) ? {TIME_W{1'b1}}
                                                     : div_q[TIME_W-1:0];
        window_fill <= '0;
        saturated   <= sat_r;
      end else begin
        estimate    <= cand;
        window_fill <= LIMIT_W'(fill_r);
        saturated   <= 1'b0;
      end
    end
  end

  // checks
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall)
    else $error("sample taken during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second sample taken while one is in work");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> rank <= fill_r && iss_j <= fill_r)
    else $error("rank count ran past window fill");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_rem < div_c)
    else $error("divider remainder not below divisor");

endmodule

### sim/tb_keyed_exec_time_tracker.sv
// tb_keyed_exec_time_tracker: self-checking bench for the keyed execution-time tracker,
// with a local per-key mean and sliding-median predictor, directed and random stimulus
// depends on ket_pkg and keyed_exec_time_tracker
`timescale 1ns / 100ps

module tb_keyed_exec_time_tracker;
  import ket_pkg::*;

  localparam int NKEYS      = OP_KINDS_DEF * UNIT_KINDS_DEF;
  localparam int WIN        = MAX_WINDOW_DEF;
  localparam int CYCLE_CAP  = 4000000;
  localparam logic [SUM_W-1:0]  SUM_TOP  = '1;
  localparam logic [CNT_W-1:0]  CNT_TOP  = '1;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;

  typedef struct packed {
    logic [TIME_W-1:0]  est;
    logic [LIMIT_W-1:0] fill;
    logic               sat;
  } estimate_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_STAT_MODE;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op_kind = '0;
  logic [UNIT_W-1:0]  unit_kind = '0;
  logic [TIME_W-1:0]  sample_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TIME_W-1:0]  estimate;
  logic [LIMIT_W-1:0] window_fill;
  logic               saturated;

  // predictor copy of configuration and per-key statistics
  logic               pred_mode;
  logic [LIMIT_W-1:0] pred_limit;
  logic [TIME_W-1:0]  ring [NKEYS][WIN];
  int                 med_fill [NKEYS];
  int                 med_old [NKEYS];
  logic [SUM_W-1:0]   mean_sum [NKEYS];
  logic [CNT_W-1:0]   mean_cnt [NKEYS];

  estimate_t pending_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        burst_left = 0;
  bit        valid_up = 1'b0;
  int        stall_style = 0;

  keyed_exec_time_tracker DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op_kind(op_kind), .unit_kind(unit_kind), .sample_time(sample_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .estimate(estimate), .window_fill(window_fill), .saturated(saturated)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall pattern, chosen at random among four styles
  always @(posedge clk) begin
    if (cycles % 200 == 0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ((cycles / 13) % 2 == 1);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    estimate_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: estimate %0d", estimate);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (estimate !== want.est) begin
          $error("estimate: expected %0d, got %0d", want.est, estimate);
          errors++;
        end
        if (window_fill !== want.fill) begin
          $error("window_fill: expected %0d, got %0d", want.fill, window_fill);
          errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, saturated);
          errors++;
        end
      end
    end
  end

  // sliding window update, returns upper middle of the sorted window
  function automatic logic [TIME_W-1:0] window_median(int key, logic [TIME_W-1:0] t,
                                                       output int fill_o);
    logic [TIME_W-1:0] srt [WIN];
    logic [TIME_W-1:0] v;
    int lim, fill, old, j;
    lim  = (pred_limit == 0) ? 1 : ((pred_limit > WIN) ? WIN : pred_limit);
    fill = med_fill[key];
    old  = med_old[key];
    if (fill > lim) begin
      old  = (old + fill - lim) % WIN;
      fill = lim;
    end
    if (fill < lim) begin
      ring[key][(old + fill) % WIN] = t;
      fill++;
    end else begin
      ring[key][old] = t;
      old = (old + 1) % WIN;
    end
    med_fill[key] = fill;
    med_old[key]  = old;
    for (int i = 0; i < fill; i++) begin
      v = ring[key][(old + i) % WIN];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    fill_o = fill;
    return srt[fill / 2];
  endfunction

  function automatic estimate_t predict_estimate(logic [OP_W-1:0] op, logic [UNIT_W-1:0] unit,
                                                 logic [TIME_W-1:0] t);
    estimate_t r;
    int key, f;
    logic [SUM_W-1:0] s, q;
    logic [CNT_W-1:0] c;
    key = op * UNIT_KINDS_DEF + unit;
    if (pred_mode == MODE_MEAN) begin
      s = mean_sum[key];
      c = mean_cnt[key];
      s = (s > SUM_TOP - t) ? SUM_TOP : s + t;
      if (c != CNT_TOP) c++;
      mean_sum[key] = s;
      mean_cnt[key] = c;
      q = s / c;
      r.est  = (q > TIME_TOP) ? TIME_TOP : q[TIME_W-1:0];
      r.fill = '0;
      r.sat  = (s == SUM_TOP) || (c == CNT_TOP);
    end else begin
      r.est  = window_median(key, t, f);
      r.fill = f[LIMIT_W-1:0];
      r.sat  = 1'b0;
    end
    return r;
  endfunction

  // one sample beat, with bursts and random gaps after acceptance
  task automatic send_sample(logic [OP_W-1:0] op, logic [UNIT_W-1:0] unit,
                             logic [TIME_W-1:0] t);
    estimate_t exp_beat;
    int gap;
    in_valid    <= 1'b1;
    valid_up    = 1'b1;
    op_kind     <= op;
    unit_kind   <= unit;
    sample_time <= t;
    do @(posedge clk); while (in_stall);
    exp_beat  = predict_estimate(op, unit, t);
    pending_q = {pending_q, exp_beat};
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // drain all results, then let the block settle before touching it
  task automatic wait_idle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LIMIT_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STAT_MODE) pred_mode = val[0];
    else pred_limit = val;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 5))
      0: return TIME_W'({$urandom, $urandom});
      1: return TIME_W'($urandom_range(0, 100));
      2: return TIME_TOP - TIME_W'($urandom_range(0, 3));
      3: return $urandom_range(0, 1) ? '0 : TIME_TOP;
      default: return TIME_W'($urandom_range(0, 1000000));
    endcase
  endfunction

  // reset values: median mode, limit 25; key and value extremes
  task automatic test_reset_defaults();
    send_sample(3'd0, 2'd0, '0);
    send_sample(3'd7, 2'd3, TIME_TOP);
    send_sample(3'd7, 2'd3, 48'd5);
    send_sample(3'd7, 2'd3, 48'd1);
    send_sample(3'd5, 2'd2, 48'h555555555555);
    send_sample(3'd2, 2'd1, 48'haaaaaaaaaaaa);
  endtask

  // mean mode: large samples, zero, separate statistics per key
  task automatic test_mean_mode();
    write_reg(REG_STAT_MODE, LIMIT_W'(MODE_MEAN));
    send_sample(3'd0, 2'd0, TIME_TOP);
    send_sample(3'd0, 2'd0, TIME_TOP);
    send_sample(3'd0, 2'd0, '0);
    send_sample(3'd7, 2'd3, 48'd7);
    send_sample(3'd7, 2'd3, 48'd2);
  endtask

  // lowering the limit below fill drops the oldest samples
  task automatic test_window_shrink();
    write_reg(REG_STAT_MODE, LIMIT_W'(MODE_MEDIAN));
    write_reg(REG_WINDOW_LIMIT, 6'd5);
    for (int i = 0; i < 4; i++) send_sample(3'd4, 2'd1, TIME_W'(100 - i * 7));
    write_reg(REG_WINDOW_LIMIT, 6'd2);
    send_sample(3'd4, 2'd1, 48'd3);
    send_sample(3'd4, 2'd1, 48'd90);
  endtask

  // limit zero acts as one, limit above the window acts as the full window
  task automatic test_limit_extremes();
    write_reg(REG_WINDOW_LIMIT, 6'd0);
    send_sample(3'd1, 2'd2, 48'd9);
    send_sample(3'd1, 2'd2, 48'd4);
    write_reg(REG_WINDOW_LIMIT, 6'd63);
    send_sample(3'd1, 2'd2, 48'd6);
    send_sample(3'd1, 2'd2, 48'd8);
  endtask

  // random phases: fresh configuration each phase, keys mostly from a narrow set
  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] lim;
    logic [OP_W-1:0] hot_op;
    logic [UNIT_W-1:0] hot_unit;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0: lim = 6'd1;
        1: lim = 6'd32;
        2: lim = LIMIT_W'($urandom_range(33, 63));
        3: lim = 6'd0;
        default: lim = LIMIT_W'($urandom_range(2, 8));
      endcase
      write_reg(REG_WINDOW_LIMIT, lim);
      write_reg(REG_STAT_MODE, LIMIT_W'($urandom_range(0, 1)));
      hot_op   = OP_W'($urandom);
      hot_unit = UNIT_W'($urandom);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 3) != 0)
          send_sample(hot_op ^ OP_W'($urandom_range(0, 1)), hot_unit, rand_time());
        else
          send_sample(OP_W'($urandom), UNIT_W'($urandom), rand_time());
      end
    end
  endtask

  initial begin
    pred_mode  = MODE_RESET;
    pred_limit = LIMIT_RESET;
    for (int k = 0; k < NKEYS; k++) begin
      med_fill[k] = 0;
      med_old[k]  = 0;
      mean_sum[k] = '0;
      mean_cnt[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_mean_mode();
    test_window_shrink();
    test_limit_extremes();
    test_random_traffic();
    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ket_pkg.sv
hw/rtl/keyed_exec_time_tracker.sv
sim/tb_keyed_exec_time_tracker.sv
